/* rtl/blfp_pkg.sv */
`default_nettype none
package blfp_pkg;

    localparam int TOK_DEPTH_DEF = 4;
    localparam int RES_DEPTH_DEF = 2;

    // character class seen by the parser
    typedef enum logic [3:0] {
        CLS_SPACE,
        CLS_DIGIT,
        CLS_LETTER,
        CLS_LT,
        CLS_GT,
        CLS_BANG,
        CLS_EQ,
        CLS_LBRK,
        CLS_RBRK,
        CLS_DOT,
        CLS_OTHER
    } t_cls;

    typedef enum logic [1:0] {
        KIND_REG  = 2'd0,
        KIND_ARR  = 2'd1,
        KIND_VEC  = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ORD_NATIVE = 2'd0,
        ORD_LITTLE = 2'd1,
        ORD_BIG    = 2'd2
    } t_order;

    // classified character; val is the digit value or the letter index
    typedef struct packed {
        logic       eot;
        t_cls       cls;
        logic [3:0] val;
    } t_tok;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  code;
        logic [63:0] count_or_min;
        logic [63:0] range_max;
        t_order      order;
        logic        err;
        logic        last;
    } t_rec;

    localparam int TOK_W = $bits(t_tok);
    localparam int REC_W = $bits(t_rec);

endpackage
`default_nettype wire

/* rtl/blfp_fifo.sv */
`default_nettype none
module blfp_fifo
    import blfp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/blfp_front.sv */
`default_nettype none
module blfp_front
    import blfp_pkg::*;
(
    input  wire logic [7:0] i_ch,
    input  wire logic       i_eot,
    output t_tok            o_tok
);

    always_comb begin
        o_tok.eot = i_eot;
        o_tok.cls = CLS_OTHER;
        o_tok.val = i_ch[3:0];
        priority if (i_ch >= 8'h30 && i_ch <= 8'h39) begin
            o_tok.cls = CLS_DIGIT;
        end else begin
            unique case (i_ch)
                8'h20: o_tok.cls = CLS_SPACE;
                8'h3c: o_tok.cls = CLS_LT;
                8'h3e: o_tok.cls = CLS_GT;
                8'h21: o_tok.cls = CLS_BANG;
                8'h3d: o_tok.cls = CLS_EQ;
                8'h5b: o_tok.cls = CLS_LBRK;
                8'h5d: o_tok.cls = CLS_RBRK;
                8'h2e: o_tok.cls = CLS_DOT;
                8'h62: begin o_tok.cls = CLS_LETTER; o_tok.val = 4'd0; end  // b
                8'h42: begin o_tok.cls = CLS_LETTER; o_tok.val = 4'd1; end  // B
                8'h68: begin o_tok.cls = CLS_LETTER; o_tok.val = 4'd2; end  // h
                8'h48: begin o_tok.cls = CLS_LETTER; o_tok.val = 4'd3; end  // H
                8'h6c: begin o_tok.cls = CLS_LETTER; o_tok.val = 4'd4; end  // l
                8'h4c: begin o_tok.cls = CLS_LETTER; o_tok.val = 4'd5; end  // L
                8'h71: begin o_tok.cls = CLS_LETTER; o_tok.val = 4'd6; end  // q
                8'h51: begin o_tok.cls = CLS_LETTER; o_tok.val = 4'd7; end  // Q
                default: o_tok.cls = CLS_OTHER;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/blfp_back.sv */
`default_nettype none
module blfp_back
    import blfp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_tok i_tok,
    input  wire logic i_tok_valid,
    input  wire logic i_res_full,
    output logic      o_tok_take,
    output t_rec      o_rec,
    output logic      o_rec_push
);

    typedef enum logic [3:0] {
        ST_START,
        ST_CMD,
        ST_CMD_SP,
        ST_AFTER_LET,
        ST_COUNT,
        ST_ARR_NUM,
        ST_ARR_TAIL,
        ST_VEC_LO,
        ST_VEC_LO_T,
        ST_VEC_DOT,
        ST_VEC_HI,
        ST_VEC_HI_T,
        ST_DROP
    } t_state;

    t_state      r_state, n_state;
    t_order      r_order, n_order;
    logic [2:0]  r_code, n_code;
    logic [63:0] r_accum, n_accum;
    logic [63:0] r_low, n_low;
    logic        r_saw, n_saw;
    logic [63:0] acc_dig;
    logic [2:0]  let_idx;
    t_cls        cls;

    assign o_tok_take = i_tok_valid && !i_res_full;
    assign cls        = i_tok.cls;
    assign let_idx    = i_tok.val[2:0];
    // accum * 10 + digit as shift-add
    assign acc_dig = {r_accum[60:0], 3'b000} + {r_accum[62:0], 1'b0} + 64'(i_tok.val);

    always_comb begin
        n_state = r_state;
        n_order = r_order;
        n_code  = r_code;
        n_accum = r_accum;
        n_low   = r_low;
        n_saw   = r_saw;
        o_rec_push         = 1'b0;
        o_rec.kind         = KIND_NONE;
        o_rec.code         = '0;
        o_rec.count_or_min = '0;
        o_rec.range_max    = '0;
        o_rec.order        = r_order;
        o_rec.err          = 1'b0;
        o_rec.last         = 1'b0;

        if (o_tok_take) begin
            if (i_tok.eot) begin
                o_rec.last = 1'b1;
                o_rec_push = 1'b1;
                unique case (r_state)
                    ST_START, ST_CMD: ;
                    ST_AFTER_LET: begin
                        o_rec.kind         = KIND_REG;
                        o_rec.code         = r_code;
                        o_rec.count_or_min = 64'd1;
                    end
                    ST_COUNT: begin
                        o_rec.kind         = KIND_REG;
                        o_rec.code         = r_code;
                        o_rec.count_or_min = r_accum;
                    end
                    ST_DROP: o_rec_push = 1'b0;
                    default: o_rec.err = 1'b1;
                endcase
                n_state = ST_START;
                n_order = ORD_NATIVE;
                n_code  = '0;
                n_accum = '0;
                n_low   = '0;
                n_saw   = 1'b0;
            end else begin
                unique case (r_state)
                    ST_START: begin
                        priority case (cls)
                            CLS_SPACE: ;
                            CLS_LT: begin n_order = ORD_LITTLE; n_state = ST_CMD; end
                            CLS_GT, CLS_BANG: begin
                                n_order = ORD_BIG;
                                n_state = ST_CMD;
                            end
                            CLS_EQ: n_state = ST_CMD;
                            CLS_LETTER: begin
                                n_code = let_idx; n_accum = '0; n_saw = 1'b0;
                                n_state = ST_AFTER_LET;
                            end
                            default: begin o_rec.err = 1'b1; o_rec_push = 1'b1; end
                        endcase
                    end
                    ST_CMD, ST_CMD_SP: begin
                        priority case (cls)
                            CLS_SPACE: n_state = ST_CMD_SP;
                            CLS_LETTER: begin
                                n_code = let_idx; n_accum = '0; n_saw = 1'b0;
                                n_state = ST_AFTER_LET;
                            end
                            default: begin o_rec.err = 1'b1; o_rec_push = 1'b1; end
                        endcase
                    end
                    ST_AFTER_LET: begin
                        priority case (cls)
                            CLS_SPACE: ;
                            CLS_LBRK: begin
                                n_accum = '0; n_saw = 1'b0; n_state = ST_ARR_NUM;
                            end
                            CLS_LT: begin
                                n_accum = '0; n_saw = 1'b0; n_state = ST_VEC_LO;
                            end
                            CLS_DIGIT: begin
                                n_accum = 64'(i_tok.val); n_saw = 1'b1;
                                n_state = ST_COUNT;
                            end
                            CLS_LETTER: begin
                                // previous letter closes with count 1
                                o_rec.kind = KIND_REG; o_rec.code = r_code;
                                o_rec.count_or_min = 64'd1; o_rec_push = 1'b1;
                                n_code = let_idx; n_accum = '0; n_saw = 1'b0;
                            end
                            default: begin o_rec.err = 1'b1; o_rec_push = 1'b1; end
                        endcase
                    end
                    ST_COUNT: begin
                        priority case (cls)
                            CLS_DIGIT: begin n_accum = acc_dig; n_saw = 1'b1; end
                            CLS_SPACE: begin
                                o_rec.kind = KIND_REG; o_rec.code = r_code;
                                o_rec.count_or_min = r_accum; o_rec_push = 1'b1;
                                n_state = ST_CMD_SP;
                            end
                            CLS_LETTER: begin
                                o_rec.kind = KIND_REG; o_rec.code = r_code;
                                o_rec.count_or_min = r_accum; o_rec_push = 1'b1;
                                n_code = let_idx; n_accum = '0; n_saw = 1'b0;
                                n_state = ST_AFTER_LET;
                            end
                            default: begin o_rec.err = 1'b1; o_rec_push = 1'b1; end
                        endcase
                    end
                    ST_ARR_NUM, ST_ARR_TAIL: begin
                        priority if (cls == CLS_RBRK) begin
                            o_rec.kind = KIND_ARR; o_rec.code = r_code;
                            o_rec.count_or_min = r_accum; o_rec_push = 1'b1;
                            n_state = ST_CMD;
                        end else if (cls == CLS_SPACE) begin
                            if (r_saw) n_state = ST_ARR_TAIL;
                        end else if (r_state == ST_ARR_NUM && cls == CLS_DIGIT) begin
                            n_accum = acc_dig; n_saw = 1'b1;
                        end else begin
                            o_rec.err = 1'b1; o_rec_push = 1'b1;
                        end
                    end
                    ST_VEC_LO, ST_VEC_LO_T: begin
                        priority if (cls == CLS_DOT) begin
                            n_low = r_accum; n_state = ST_VEC_DOT;
                        end else if (cls == CLS_SPACE) begin
                            if (r_saw) n_state = ST_VEC_LO_T;
                        end else if (r_state == ST_VEC_LO && cls == CLS_DIGIT) begin
                            n_accum = acc_dig; n_saw = 1'b1;
                        end else begin
                            o_rec.err = 1'b1; o_rec_push = 1'b1;
                        end
                    end
                    ST_VEC_DOT: begin
                        if (cls == CLS_DOT) begin
                            n_accum = '0; n_saw = 1'b0; n_state = ST_VEC_HI;
                        end else begin
                            o_rec.err = 1'b1; o_rec_push = 1'b1;
                        end
                    end
                    ST_VEC_HI, ST_VEC_HI_T: begin
                        priority if (cls == CLS_GT) begin
                            o_rec.kind = KIND_VEC; o_rec.code = r_code;
                            o_rec.count_or_min = r_low; o_rec.range_max = r_accum;
                            o_rec_push = 1'b1;
                            n_state = ST_CMD;
                        end else if (cls == CLS_SPACE) begin
                            if (r_saw) n_state = ST_VEC_HI_T;
                        end else if (r_state == ST_VEC_HI && cls == CLS_DIGIT) begin
                            n_accum = acc_dig; n_saw = 1'b1;
                        end else begin
                            o_rec.err = 1'b1; o_rec_push = 1'b1;
                        end
                    end
                    default: n_state = ST_DROP;
                endcase
                // any syntax error drops the rest of the text
                if (o_rec.err) begin
                    n_state = ST_DROP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_order <= ORD_NATIVE;
            r_code  <= '0;
            r_accum <= '0;
            r_low   <= '0;
            r_saw   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_order <= n_order;
            r_code  <= n_code;
            r_accum <= n_accum;
            r_low   <= n_low;
            r_saw   <= n_saw;
        end
    end

endmodule
`default_nettype wire

/* rtl/binary_layout_format_parser.sv */
// Binary-layout format text parser.
//
// Input channel (queue style): one character per transfer on i_ch, or an
// end-of-text marker on i_end_of_text. A transfer happens when push is high
// and full is low. An optional byte-order prefix, then integer commands with
// a repeat count, an [n] array or a <min..max> vector.
// Result channel (queue style): while empty is low the oldest record sits on
// the o_* ports; pop with empty low takes it. One record per finished
// command. A syntax error gives one error record and the rest of the text,
// end marker included, is dropped. Otherwise the end marker gives a closing
// record; last is set only on a record caused by the end marker.
// A character is registered in the token queue and the record it causes in
// the result queue. Throughput: one character per cycle while the result
// queue is not full; the back end's decimal update is a single shift-add per cycle.
// The classifier feeds a token queue of TOK_DEPTH entries; the parser
// drains it into a result queue of RES_DEPTH entries. When the receiver
// stalls, the result queue fills, the parser stops, the token queue fills
// and full rises. No item is lost.
// Reset (synchronous, active low) empties both queues and returns the
// parser to the start of text.
`default_nettype none
module binary_layout_format_parser
    import blfp_pkg::*;
#(
    parameter int TOK_DEPTH = TOK_DEPTH_DEF,
    parameter int RES_DEPTH = RES_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_end_of_text,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_kind,
    output logic [2:0]       o_int_code,
    output logic [63:0]      o_count_or_min,
    output logic [63:0]      o_range_max,
    output logic [1:0]       o_byte_order,
    output logic             o_error,
    output logic             o_last
);

    t_tok             tok_in, tok_out;
    logic [TOK_W-1:0] tok_out_vec;
    logic             tok_empty, tok_take;
    t_rec             rec_in, rec_out;
    logic [REC_W-1:0] rec_out_vec;
    logic             rec_push, res_full;

    // front: classify each character as it is transferred
    blfp_front u_front (
        .i_ch  (i_ch),
        .i_eot (i_end_of_text),
        .o_tok (tok_in)
    );

    // token queue decouples input from parser
    blfp_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (TOK_DEPTH)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (tok_in),
        .i_rd    (tok_take),
        .o_data  (tok_out_vec),
        .o_full  (full),
        .o_empty (tok_empty)
    );

    assign tok_out = t_tok'(tok_out_vec);

    // back: syntax state machine and number accumulation
    blfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (tok_out),
        .i_tok_valid (!tok_empty),
        .i_res_full  (res_full),
        .o_tok_take  (tok_take),
        .o_rec       (rec_in),
        .o_rec_push  (rec_push)
    );

    // result queue; parts parser from a stalling receiver
    blfp_fifo #(
        .WIDTH (REC_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rec_push),
        .i_data  (rec_in),
        .i_rd    (pop),
        .o_data  (rec_out_vec),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign rec_out        = t_rec'(rec_out_vec);
    assign o_kind         = rec_out.kind;
    assign o_int_code     = rec_out.code;
    assign o_count_or_min = rec_out.count_or_min;
    assign o_range_max    = rec_out.range_max;
    assign o_byte_order   = rec_out.order;
    assign o_error        = rec_out.err;
    assign o_last         = rec_out.last;

endmodule
`default_nettype wire

/* rtl/blfp_checker.sv */
`default_nettype none
module blfp_checker
    import blfp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  o_kind,
    input wire logic [2:0]  o_int_code,
    input wire logic [63:0] o_count_or_min,
    input wire logic [63:0] o_range_max,
    input wire logic [1:0]  o_byte_order,
    input wire logic        o_error,
    input wire logic        o_last
);

    // reset empties both queues
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // a waiting record holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_int_code)
                              && $stable(o_count_or_min) && $stable(o_range_max)
                              && $stable(o_byte_order) && $stable(o_error)
                              && $stable(o_last)))
        else $error("stalled record changed");

    // error record carries no command
    a_err_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error) |-> (o_kind == KIND_NONE && o_int_code == '0
                                 && o_count_or_min == '0))
        else $error("malformed error record");

    // a record without a command and without error only closes a text
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_NONE && !o_error) |-> (o_last && o_int_code == '0))
        else $error("no-command record not last");

    // only vectors carry a maximum
    a_max_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != KIND_VEC) |-> (o_range_max == '0))
        else $error("range_max set on non-vector record");

endmodule

bind binary_layout_format_parser blfp_checker u_blfp_checker (.*);
`default_nettype wire

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import blfp_pkg::*;

    // Run shape
    localparam int ITEMS       = 1800;  // live items to push, end markers included (dropped ones excluded)
    localparam int HOLD_CYCLES = 100;   // receiver hold-off used to back the block up
    localparam int QUIET_LIMIT = 1000;  // cycles without any transfer before giving up
    localparam int DRAIN_WAIT  = 8;     // extra wait once no record is owed any more

    // Letter index as carried on o_int_code
    localparam logic [2:0] INT_S8  = 3'd0;  // b
    localparam logic [2:0] INT_U8  = 3'd1;  // B
    localparam logic [2:0] INT_S16 = 3'd2;  // h
    localparam logic [2:0] INT_U16 = 3'd3;  // H
    localparam logic [2:0] INT_S32 = 3'd4;  // l
    localparam logic [2:0] INT_U32 = 3'd5;  // L
    localparam logic [2:0] INT_S64 = 3'd6;  // q
    localparam logic [2:0] INT_U64 = 3'd7;  // Q

    localparam logic [7:0] LETTERS [8] = '{"b", "B", "h", "H", "l", "L", "q", "Q"};
    localparam logic [7:0] PREFIXES[4] = '{"<", ">", "!", "="};

    // Parser position inside the text
    typedef enum logic [3:0] {
        PS_START, PS_CMD, PS_CMD_SP, PS_AFTER_LET, PS_COUNT,
        PS_ARR_NUM, PS_ARR_TAIL, PS_VEC_LO, PS_VEC_LO_T,
        PS_VEC_DOT, PS_VEC_HI, PS_VEC_HI_T, PS_DROP
    } t_pstate;

    // One directed stimulus row; rec is the hand-written record when known is set
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        bit         known;
        t_rec       rec;
    } t_row;

    // DUT-facing signals; the ones the bench drives are known from time zero
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        push           = 1'b0;
    logic [7:0]  i_ch           = 8'h00;
    logic        i_end_of_text  = 1'b0;
    logic        pop            = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  o_kind;
    logic [2:0]  o_int_code;
    logic [63:0] o_count_or_min;
    logic [63:0] o_range_max;
    logic [1:0]  o_byte_order;
    logic        o_error;
    logic        o_last;

    // Parser shadow state
    t_pstate     ps      = PS_START;
    t_order      p_order = ORD_NATIVE;
    logic [2:0]  p_code  = 3'd0;
    logic [63:0] p_acc   = 64'd0;
    logic [63:0] p_low   = 64'd0;
    logic        p_digit = 1'b0;

    t_rec        rec_q[$];          // records still owed by the block
    t_row        rows[$];
    logic [7:0]  txt[$];            // random text under construction

    // Hand-written record riding along with the character being offered
    bit          typed_ok  = 1'b0;
    t_rec        typed_rec = '0;

    int          idle_pct      = 0;
    int          stall_pct     = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;

    int          live_items = 0;
    int          errors     = 0;
    int          n_texts    = 0;
    int          n_records  = 0;
    int          n_errrec   = 0;
    int          n_arr      = 0;
    int          n_vec      = 0;

    binary_layout_format_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_ch           (i_ch),
        .i_end_of_text  (i_end_of_text),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_int_code     (o_int_code),
        .o_count_or_min (o_count_or_min),
        .o_range_max    (o_range_max),
        .o_byte_order   (o_byte_order),
        .o_error        (o_error),
        .o_last         (o_last)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Parser shadow
    // ------------------------------------------------------------------
    function automatic t_rec rec_of(t_kind k, logic [2:0] code, logic [63:0] a,
                                    logic [63:0] b, t_order o, logic err, logic last);
        t_rec r;
        r.kind         = k;
        r.code         = code;
        r.count_or_min = a;
        r.range_max    = b;
        r.order        = o;
        r.err          = err;
        r.last         = last;
        return r;
    endfunction

    function automatic int letter_of(logic [7:0] c);
        for (int i = 0; i < 8; i++)
            if (LETTERS[i] == c)
                return i;
        return -1;
    endfunction

    function automatic void start_num(t_pstate nxt);
        p_acc   = 64'd0;
        p_digit = 1'b0;
        ps      = nxt;
    endfunction

    function automatic void start_cmd(int li);
        p_code = li[2:0];
        start_num(PS_AFTER_LET);
    endfunction

    // decimal accumulate (times ten plus digit), wraps at 64 bits
    function automatic void add_digit(logic [7:0] c);
        p_acc   = p_acc * 64'd10 + {60'd0, c[3:0]};
        p_digit = 1'b1;
    endfunction

    // syntax error in mid-text: drop everything up to the end marker
    function automatic t_rec syntax_fail();
        ps = PS_DROP;
        return rec_of(KIND_NONE, 3'd0, 64'd0, 64'd0, p_order, 1'b1, 1'b0);
    endfunction

    // Advance the shadow by one accepted item; returns 1 when a record is owed
    function automatic bit parse_step(input logic [7:0] c, input logic e, output t_rec r);
        int li;
        bit dig;
        bit got;
        li  = letter_of(c);
        dig = (c >= "0") && (c <= "9");
        got = 1'b0;
        r   = '0;
        if (e) begin
            got = 1'b1;
            case (ps)
                PS_START, PS_CMD:
                    r = rec_of(KIND_NONE, 3'd0, 64'd0, 64'd0, p_order, 1'b0, 1'b1);
                PS_AFTER_LET:
                    r = rec_of(KIND_REG, p_code, 64'd1, 64'd0, p_order, 1'b0, 1'b1);
                PS_COUNT:
                    r = rec_of(KIND_REG, p_code, p_acc, 64'd0, p_order, 1'b0, 1'b1);
                PS_DROP:
                    got = 1'b0;
                default:
                    r = rec_of(KIND_NONE, 3'd0, 64'd0, 64'd0, p_order, 1'b1, 1'b1);
            endcase
            ps      = PS_START;
            p_order = ORD_NATIVE;
            p_code  = 3'd0;
            p_acc   = 64'd0;
            p_low   = 64'd0;
            p_digit = 1'b0;
        end else begin
            case (ps)
                PS_START: begin
                    if (c == "<") begin
                        p_order = ORD_LITTLE;
                        ps      = PS_CMD;
                    end else if (c == ">" || c == "!") begin
                        p_order = ORD_BIG;
                        ps      = PS_CMD;
                    end else if (c == "=") begin
                        ps = PS_CMD;
                    end else if (li >= 0) begin
                        start_cmd(li);
                    end else if (c != " ") begin
                        r   = syntax_fail();
                        got = 1'b1;
                    end
                end
                PS_CMD, PS_CMD_SP: begin
                    if (c == " ") begin
                        ps = PS_CMD_SP;
                    end else if (li >= 0) begin
                        start_cmd(li);
                    end else begin
                        r   = syntax_fail();
                        got = 1'b1;
                    end
                end
                PS_AFTER_LET: begin
                    if (c == "[") begin
                        start_num(PS_ARR_NUM);
                    end else if (c == "<") begin
                        start_num(PS_VEC_LO);
                    end else if (dig) begin
                        start_num(PS_COUNT);
                        add_digit(c);
                    end else if (li >= 0) begin
                        // bare letter closed by the next letter: count of one
                        r   = rec_of(KIND_REG, p_code, 64'd1, 64'd0, p_order, 1'b0, 1'b0);
                        got = 1'b1;
                        start_cmd(li);
                    end else if (c != " ") begin
                        r   = syntax_fail();
                        got = 1'b1;
                    end
                end
                PS_COUNT: begin
                    if (dig) begin
                        add_digit(c);
                    end else if (c == " " || li >= 0) begin
                        r   = rec_of(KIND_REG, p_code, p_acc, 64'd0, p_order, 1'b0, 1'b0);
                        got = 1'b1;
                        if (li >= 0)
                            start_cmd(li);
                        else
                            ps = PS_CMD_SP;
                    end else begin
                        r   = syntax_fail();
                        got = 1'b1;
                    end
                end
                PS_ARR_NUM, PS_ARR_TAIL: begin
                    if (c == "]") begin
                        r   = rec_of(KIND_ARR, p_code, p_acc, 64'd0, p_order, 1'b0, 1'b0);
                        got = 1'b1;
                        ps  = PS_CMD;
                    end else if (c == " ") begin
                        if (p_digit)
                            ps = PS_ARR_TAIL;
                    end else if (ps == PS_ARR_NUM && dig) begin
                        add_digit(c);
                    end else begin
                        r   = syntax_fail();
                        got = 1'b1;
                    end
                end
                PS_VEC_LO, PS_VEC_LO_T: begin
                    if (c == ".") begin
                        p_low = p_acc;
                        ps    = PS_VEC_DOT;
                    end else if (c == " ") begin
                        if (p_digit)
                            ps = PS_VEC_LO_T;
                    end else if (ps == PS_VEC_LO && dig) begin
                        add_digit(c);
                    end else begin
                        r   = syntax_fail();
                        got = 1'b1;
                    end
                end
                PS_VEC_DOT: begin
                    if (c == ".") begin
                        start_num(PS_VEC_HI);
                    end else begin
                        r   = syntax_fail();
                        got = 1'b1;
                    end
                end
                PS_VEC_HI, PS_VEC_HI_T: begin
                    if (c == ">") begin
                        r   = rec_of(KIND_VEC, p_code, p_low, p_acc, p_order, 1'b0, 1'b0);
                        got = 1'b1;
                        ps  = PS_CMD;
                    end else if (c == " ") begin
                        if (p_digit)
                            ps = PS_VEC_HI_T;
                    end else if (ps == PS_VEC_HI && dig) begin
                        add_digit(c);
                    end else begin
                        r   = syntax_fail();
                        got = 1'b1;
                    end
                end
                default: ps = PS_DROP;  // dropping until the end marker
            endcase
        end
        return got;
    endfunction

    // ------------------------------------------------------------------
    // Random text generation
    // ------------------------------------------------------------------
    function automatic void put_spaces();
        repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
            txt.push_back(" ");
    endfunction

    // Mostly short numbers; some 20-digit ones to wrap the 64-bit value;
    // empty numbers only where the syntax allows them
    function automatic void put_number(bit may_be_empty);
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 8)
            n = 20;
        else if (may_be_empty && r < 20)
            n = 0;
        else
            n = $urandom_range(1, 3);
        repeat (n)
            txt.push_back("0" + 8'($urandom_range(9)));
    endfunction

    // Mostly well-formed text with random content; some with one stray
    // character dropped in, a few made of pure noise
    function automatic void build_text();
        int style;
        int pre;
        int ncmd;
        txt.delete();
        style = $urandom_range(99);
        if (style < 6) begin
            repeat ($urandom_range(1, 8))
                txt.push_back(8'($urandom));
        end else begin
            pre = $urandom_range(5);
            if (pre < 4) begin
                txt.push_back(PREFIXES[pre]);
                put_spaces();
            end
            ncmd = $urandom_range(1, 5);
            for (int i = 0; i < ncmd; i++) begin
                txt.push_back(LETTERS[$urandom_range(7)]);
                case ($urandom_range(3))
                    1: begin
                        put_spaces();
                        put_number(1'b0);
                    end
                    2: begin
                        txt.push_back("[");
                        put_spaces();
                        put_number(1'b1);
                        put_spaces();
                        txt.push_back("]");
                    end
                    3: begin
                        txt.push_back("<");
                        put_spaces();
                        put_number(1'b1);
                        put_spaces();
                        txt.push_back(".");
                        txt.push_back(".");
                        put_spaces();
                        put_number(1'b1);
                        put_spaces();
                        txt.push_back(">");
                    end
                    default: ;  // bare letter, count of one
                endcase
                if (i < ncmd - 1)
                    put_spaces();
            end
            if ($urandom_range(9) == 0)
                txt.push_back(" ");  // trailing space before the end marker
            if (style < 20)
                txt.insert($urandom_range(txt.size()), 8'($urandom));
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one item, hold it until the transfer happens.
    // push is only lowered while idling, so it is never dropped and
    // raised in the same step.
    // ------------------------------------------------------------------
    task automatic send(input logic [7:0] c, input logic e, input bit known, input t_rec r);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_ch          <= c;
        i_end_of_text <= e;
        typed_ok      <= known;
        typed_rec     <= r;
        do
            @(posedge i_clk);
        while (full);
    endtask

    function automatic void plain(logic [7:0] c, logic e);
        rows.push_back('{c, e, 1'b0, t_rec'('0)});
    endfunction

    function automatic void known(logic [7:0] c, logic e, t_rec r);
        rows.push_back('{c, e, 1'b1, r});
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request so the
    // result queue fills and the block pushes back on the sender
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            pop         <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: input transfers feed the shadow, result transfers are
    // checked field by field against the oldest owed record
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_rec pred;
        t_rec want;
        bit   made;
        if (i_rst_n) begin
            if (push && !full) begin
                if (ps != PS_DROP)
                    live_items <= live_items + 1;
                if (i_end_of_text)
                    n_texts++;
                made = parse_step(i_ch, i_end_of_text, pred);
                if (typed_ok)
                    rec_q.push_back(typed_rec);
                else if (made)
                    rec_q.push_back(pred);
            end
            if (pop && !empty) begin
                if (rec_q.size() == 0) begin
                    $error("record transfer with nothing owed");
                    errors++;
                end else begin
                    want = rec_q.pop_front();
                    check_field("kind",         want.kind,         o_kind);
                    check_field("int_code",     want.code,         o_int_code);
                    check_field("count_or_min", want.count_or_min, o_count_or_min);
                    check_field("range_max",    want.range_max,    o_range_max);
                    check_field("byte_order",   want.order,        o_byte_order);
                    check_field("error",        want.err,          o_error);
                    check_field("last",         want.last,         o_last);
                    n_records++;
                    if (want.err)
                        n_errrec++;
                    if (want.kind == KIND_ARR)
                        n_arr++;
                    if (want.kind == KIND_VEC)
                        n_vec++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d records owed",
                     QUIET_LIMIT, rec_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int sel;

        // Directed table: empty text, every prefix, every letter, all three
        // command forms, missing numbers, trailing space, NUL and 0xFF
        // characters, the silent end after an error, last command on the
        // end marker
        known(8'h00, 1'b1, rec_of(KIND_NONE, 3'd0, 64'd0, 64'd0, ORD_NATIVE, 1'b0, 1'b1));
        plain("<", 1'b0);
        plain("h", 1'b0);
        plain(" ", 1'b0);                       // space after a bare letter is fine
        plain("<", 1'b0);
        plain(".", 1'b0);
        plain(".", 1'b0);
        known(">", 1'b0, rec_of(KIND_VEC, INT_S16, 64'd0, 64'd0, ORD_LITTLE, 1'b0, 1'b0));
        plain(" ", 1'b0);                       // trailing space after '>'
        known(8'h00, 1'b1, rec_of(KIND_NONE, 3'd0, 64'd0, 64'd0, ORD_LITTLE, 1'b1, 1'b1));
        plain("!", 1'b0);
        plain("B", 1'b0);
        plain("9", 1'b0);
        known("L", 1'b0, rec_of(KIND_REG, INT_U8, 64'd9, 64'd0, ORD_BIG, 1'b0, 1'b0));
        plain("[", 1'b0);
        known("]", 1'b0, rec_of(KIND_ARR, INT_U32, 64'd0, 64'd0, ORD_BIG, 1'b0, 1'b0));
        known(8'h00, 1'b0, rec_of(KIND_NONE, 3'd0, 64'd0, 64'd0, ORD_BIG, 1'b1, 1'b0));
        plain(8'hFF, 1'b0);                     // dropped
        plain(8'h00, 1'b1);                     // end after error: no record
        plain(">", 1'b0);
        plain("b", 1'b0);
        known("l", 1'b0, rec_of(KIND_REG, INT_S8, 64'd1, 64'd0, ORD_BIG, 1'b0, 1'b0));
        known("q", 1'b0, rec_of(KIND_REG, INT_S32, 64'd1, 64'd0, ORD_BIG, 1'b0, 1'b0));
        known("Q", 1'b0, rec_of(KIND_REG, INT_S64, 64'd1, 64'd0, ORD_BIG, 1'b0, 1'b0));
        known(8'h00, 1'b1, rec_of(KIND_REG, INT_U64, 64'd1, 64'd0, ORD_BIG, 1'b0, 1'b1));
        plain("=", 1'b0);
        plain("H", 1'b0);
        known(8'hFF, 1'b1, rec_of(KIND_REG, INT_U16, 64'd1, 64'd0, ORD_NATIVE, 1'b0, 1'b1));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k])
            send(rows[k].ch, rows[k].eot, rows[k].known, rows[k].rec);

        // Random part. First quarter runs flat out and opens with a long
        // receiver hold-off so full rises; then sender idling, receiver
        // stalling, and both together.
        hold_requests <= hold_requests + 1;
        while (live_items < ITEMS) begin
            sel = live_items * 4 / ITEMS;
            idle_pct  <= (sel == 1) ? 58 : (sel == 3) ? 16 : 0;
            stall_pct <= (sel == 2) ? 58 : (sel == 3) ? 16 : 0;
            build_text();
            foreach (txt[k])
                send(txt[k], 1'b0, 1'b0, '0);
            send(8'($urandom), 1'b1, 1'b0, '0);  // character is don't-care on the end marker
        end
        push <= 1'b0;

        while (rec_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d texts, %0d live characters; %0d records checked",
                 n_texts, live_items, n_records);
        $display("  of which %0d syntax errors, %0d arrays, %0d vectors",
                 n_errrec, n_arr, n_vec);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
rtl/blfp_pkg.sv
rtl/blfp_fifo.sv
rtl/blfp_front.sv
rtl/blfp_back.sv
rtl/binary_layout_format_parser.sv
rtl/blfp_checker.sv
dv/testbench.sv
